// ===== src/aes_dec_pkg.sv =====
// aes_dec_pkg: shared types, constants and functions for the aes ecb decrypt block
// no dependencies
`default_nettype none
package aes_dec_pkg;

  localparam int MaxRoundKeys = 15;
  localparam int KeySlots     = 2 * MaxRoundKeys;
  localparam int SlotW        = $clog2(KeySlots);
  localparam int RoundW       = 4;

  localparam logic CMD_KEY  = 1'b0;
  localparam logic CMD_DATA = 1'b1;

  localparam logic [1:0] REG_KEY_LEN  = 2'd0;
  localparam logic [1:0] REG_MSG_BLKS = 2'd1;

  localparam logic [1:0] MODE_128 = 2'd0;
  localparam logic [1:0] MODE_192 = 2'd1;

  localparam logic [7:0] GF_E = 8'h0e;
  localparam logic [7:0] GF_B = 8'h0b;
  localparam logic [7:0] GF_D = 8'h0d;
  localparam logic [7:0] GF_9 = 8'h09;

  typedef struct packed {
    logic        command;
    logic [4:0]  key_slot;
    logic [63:0] key_word;
    logic [7:0]  cipher_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] plain_byte;
    logic       block_last;
    logic       message_last;
  } out_item_t;

  // one round command from sequencer to the round unit
  typedef struct packed {
    logic load;   // load state from buffer and add key
    logic step;   // run one inverse round
    logic last;   // final round, no inverse mix columns
  } rnd_ctl_t;

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] gf_dbl(input logic [7:0] v);
    gf_dbl = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] v, input logic [7:0] c);
    logic [7:0] acc;
    logic [7:0] x;
    acc = 8'h00;
    x   = v;
    for (int b = 0; b < 4; b++) begin
      if (c[b]) acc = acc ^ x;
      x = gf_dbl(x);
    end
    gf_mul = acc;
  endfunction

endpackage
`default_nettype wire

// ===== src/aes_dec_round.sv =====
// aes_dec_round: shared inverse round unit, one round per cycle on a 128-bit state
// depends on aes_dec_pkg
`default_nettype none
module aes_dec_round
  import aes_dec_pkg::*;
(
  input  wire logic           clk,
  input  wire rnd_ctl_t       ctl,
  input  wire logic [127:0]   blk_in,
  input  wire logic [127:0]   rkey,
  output logic      [127:0]   state
);

  logic [127:0] ss;
  logic [127:0] ak;
  logic [127:0] mx;

  // inverse shift rows then inverse sub bytes
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        ss[(((c + r) % 4) * 4 + r) * 8 +: 8] = INV_SBOX[state[(c * 4 + r) * 8 +: 8]];
      end
    end
  end

  assign ak = ss ^ rkey;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      mx[(c*4+0)*8 +: 8] = gf_mul(ak[(c*4)*8 +: 8], GF_E) ^ gf_mul(ak[(c*4+1)*8 +: 8], GF_B)
                         ^ gf_mul(ak[(c*4+2)*8 +: 8], GF_D) ^ gf_mul(ak[(c*4+3)*8 +: 8], GF_9);
      mx[(c*4+1)*8 +: 8] = gf_mul(ak[(c*4)*8 +: 8], GF_9) ^ gf_mul(ak[(c*4+1)*8 +: 8], GF_E)
                         ^ gf_mul(ak[(c*4+2)*8 +: 8], GF_B) ^ gf_mul(ak[(c*4+3)*8 +: 8], GF_D);
      mx[(c*4+2)*8 +: 8] = gf_mul(ak[(c*4)*8 +: 8], GF_D) ^ gf_mul(ak[(c*4+1)*8 +: 8], GF_9)
                         ^ gf_mul(ak[(c*4+2)*8 +: 8], GF_E) ^ gf_mul(ak[(c*4+3)*8 +: 8], GF_B);
      mx[(c*4+3)*8 +: 8] = gf_mul(ak[(c*4)*8 +: 8], GF_B) ^ gf_mul(ak[(c*4+1)*8 +: 8], GF_D)
                         ^ gf_mul(ak[(c*4+2)*8 +: 8], GF_9) ^ gf_mul(ak[(c*4+3)*8 +: 8], GF_E);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      state <= blk_in ^ rkey;
    end else if (ctl.step) begin
      state <= ctl.last ? ak : mx;
    end
  end

endmodule
`default_nettype wire

// ===== src/block_cipher_ecb_decrypt_top.sv =====
// aes ecb decrypt on a byte stream: after the 16th data byte the block is loaded with
// the initial key add, then the inverse rounds run (nr = 10, 12 or 14), one inverse round per cycle
// in the shared round unit; the 16 bytes then leave one per cycle while out_ready is high
// a key or non-final data byte is taken without holding off input; a full block holds off input
// until its plaintext has drained, including any output stall. synchronous active-high reset clears
// control, configuration and buffer; the round key table is undefined until written
`default_nettype none
module block_cipher_ecb_decrypt_top
  import aes_dec_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data,
  input  wire logic      cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0]   fsm;
  logic [1:0]   key_len;
  logic [15:0]  msg_blks;
  logic [127:0] cbuf;
  logic [3:0]   bpos;
  logic [15:0]  bcnt;
  logic [RoundW-1:0] rnd;     // round whose key is used this cycle
  logic [RoundW-1:0] nr;
  logic [127:0] pbuf;         // plaintext being streamed out
  logic [3:0]   opos;
  logic         msg_end;
  logic         first;        // first cycle of a decrypt: initial add key

  // round key table, two halves per round
  logic [63:0]  rk_lo [MaxRoundKeys];
  logic [63:0]  rk_hi [MaxRoundKeys];
  logic [127:0] rkey;
  logic [127:0] state;
  rnd_ctl_t     ctl;

  logic in_xfer;
  logic out_xfer;
  logic blk_done;

  assign in_ready  = (fsm == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_xfer  = out_valid && out_ready;
  assign blk_done  = in_xfer && (in_data.command == CMD_DATA) && (bpos == 4'd15);

  always_comb begin
    if (key_len == MODE_128)      nr = RoundW'(10);
    else if (key_len == MODE_192) nr = RoundW'(12);
    else                          nr = RoundW'(14);
  end

  // key table: one write per key transfer to a slot inside the table
  always_ff @(posedge clk) begin
    if (in_xfer && in_data.command == CMD_KEY && in_data.key_slot < 5'(KeySlots)) begin
      if (in_data.key_slot[0]) rk_hi[in_data.key_slot[4:1]] <= in_data.key_word;
      else                     rk_lo[in_data.key_slot[4:1]] <= in_data.key_word;
    end
  end

  assign rkey = {rk_hi[rnd], rk_lo[rnd]};

  // sequencer commands for the round unit
  always_comb begin
    ctl.load = (fsm == S_RUN) && first;
    ctl.step = (fsm == S_RUN) && !first;
    ctl.last = (rnd == '0);
  end

  // full block in stream order, last byte already registered in the buffer
  logic [127:0] blk_in;
  assign blk_in = cbuf;

  aes_dec_round u_round (
    .clk    (clk),
    .ctl    (ctl),
    .blk_in (blk_in),
    .rkey   (rkey),
    .state  (state)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm      <= S_IDLE;
      key_len  <= MODE_128;
      msg_blks <= 16'd1;
      cbuf     <= '0;
      bpos     <= '0;
      bcnt     <= '0;
      rnd      <= '0;
      opos     <= '0;
      first    <= 1'b0;
      msg_end  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_KEY_LEN)  key_len  <= cfg_data[1:0];
        if (cfg_index == REG_MSG_BLKS) msg_blks <= cfg_data;
      end
      unique case (fsm)
        S_IDLE: begin
          if (in_xfer && in_data.command == CMD_DATA) begin
            cbuf[bpos*8 +: 8] <= in_data.cipher_byte;
            bpos <= bpos + 4'd1;
          end
          if (blk_done) begin
            fsm   <= S_RUN;
            first <= 1'b1;
            rnd   <= nr;
            if (17'(bcnt) + 17'd1 >= 17'(msg_blks)) begin
              msg_end <= 1'b1;
              bcnt    <= '0;
            end else begin
              msg_end <= 1'b0;
              bcnt    <= bcnt + 16'd1;
            end
          end
        end
        S_RUN: begin
          if (first) begin
            first <= 1'b0;
            rnd   <= rnd - RoundW'(1);
          end else if (rnd == '0) begin
            fsm       <= S_OUT;
            opos      <= '0;
            out_valid <= 1'b1;
          end else begin
            rnd <= rnd - RoundW'(1);
          end
        end
        S_OUT: begin
          if (out_xfer) begin
            opos <= opos + 4'd1;
            if (opos == 4'd15) begin
              out_valid <= 1'b0;
              fsm       <= S_IDLE;
            end
          end
        end
        default: fsm <= S_IDLE;
      endcase
    end
  end

  // final state registered in the round unit stays put while bytes stream out
  assign pbuf = state;
  always_comb begin
    out_data.plain_byte   = pbuf[opos*8 +: 8];
    out_data.block_last   = (opos == 4'd15);
    out_data.message_last = (opos == 4'd15) && msg_end;
  end

  // no input is taken while a block is being decrypted or drained
  a_busy_no_in: assert property (@(posedge clk) disable iff (rst)
    (fsm != S_IDLE) |-> !in_ready) else $error("input taken while busy");
  // output only in the drain phase
  a_out_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (fsm == S_OUT)) else $error("output outside drain");
  // a full block always starts the round sequence
  a_blk_start: assert property (@(posedge clk) disable iff (rst)
    blk_done |=> (fsm == S_RUN) && first) else $error("block not started");

endmodule
`default_nettype wire

// ===== tb/tb_block_cipher_ecb_decrypt_top.sv =====
// testbench for block_cipher_ecb_decrypt_top: key table writes, byte stream decryption
// depends on aes_dec_pkg and the top level; predicts plaintext with its own inverse cipher
`timescale 1ns / 1ps
`default_nettype none
module tb_block_cipher_ecb_decrypt_top;
  import aes_dec_pkg::*;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  block_cipher_ecb_decrypt_top u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  localparam int CycleLimit = 400000;

  // inverse sbox held locally so the prediction stands apart from the design
  localparam logic [7:0] UNSUB [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  // predictor state: mirrors of the key table, gather buffer and counters
  logic [63:0] key_table [KeySlots];
  logic [7:0]  gather [16];
  logic [3:0]  gather_pos;
  logic [15:0] blk_count;
  logic [1:0]  mode_reg;
  logic [15:0] msg_blocks_reg;

  in_item_t  pending_items [$];
  out_item_t expected_plain [$];
  bit        failed;
  bit        idle_off;
  int unsigned cycles;

  // clock: period 4 ns
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [7:0] xtime(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] v, input logic [7:0] c);
    logic [7:0] acc;
    acc = 8'h00;
    for (int b = 0; b < 4; b++) begin
      if (c[b]) acc ^= v;
      v = xtime(v);
    end
    return acc;
  endfunction

  // xor one round key into the state
  task automatic mix_key(inout logic [7:0] s [16], input int rnd);
    for (int i = 0; i < 8; i++) begin
      s[i]     ^= key_table[2*rnd][8*i +: 8];
      s[i + 8] ^= key_table[2*rnd + 1][8*i +: 8];
    end
  endtask

  // inverse shift rows then inverse sub bytes
  task automatic unshift_unsub(inout logic [7:0] s [16]);
    logic [7:0] t [16];
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[((c + r) % 4) * 4 + r] = s[c*4 + r];
    for (int i = 0; i < 16; i++) s[i] = UNSUB[t[i]];
  endtask

  task automatic unmix_columns(inout logic [7:0] s [16]);
    logic [7:0] a, b, d, e;
    for (int c = 0; c < 16; c += 4) begin
      a = s[c]; b = s[c+1]; d = s[c+2]; e = s[c+3];
      s[c]   = gmul(a, GF_E) ^ gmul(b, GF_B) ^ gmul(d, GF_D) ^ gmul(e, GF_9);
      s[c+1] = gmul(a, GF_9) ^ gmul(b, GF_E) ^ gmul(d, GF_B) ^ gmul(e, GF_D);
      s[c+2] = gmul(a, GF_D) ^ gmul(b, GF_9) ^ gmul(d, GF_E) ^ gmul(e, GF_B);
      s[c+3] = gmul(a, GF_B) ^ gmul(b, GF_D) ^ gmul(d, GF_9) ^ gmul(e, GF_E);
    end
  endtask

  // apply one accepted item to the predictor, queue any plaintext it produces
  task automatic predict_plaintext(input in_item_t it);
    logic [7:0] s [16];
    int nr;
    logic msg_end;
    out_item_t o;
    if (it.command == CMD_KEY) begin
      if (it.key_slot < KeySlots) key_table[it.key_slot] = it.key_word;
      return;
    end
    gather[gather_pos] = it.cipher_byte;
    if (gather_pos != 4'd15) begin
      gather_pos++;
      return;
    end
    gather_pos = 4'd0;
    s = gather;
    // mode 3 saturates to the longest key; capped by the table depth
    nr = (mode_reg == MODE_128) ? 10 : (mode_reg == MODE_192) ? 12 : 14;
    if (nr > MaxRoundKeys - 1) nr = MaxRoundKeys - 1;
    mix_key(s, nr);
    for (int r = nr - 1; r > 0; r--) begin
      unshift_unsub(s);
      mix_key(s, r);
      unmix_columns(s);
    end
    unshift_unsub(s);
    mix_key(s, 0);
    // zero message length behaves like one
    msg_end = ({16'd0, blk_count} + 32'd1 >= {16'd0, msg_blocks_reg});
    blk_count = msg_end ? 16'd0 : blk_count + 16'd1;
    for (int i = 0; i < 16; i++) begin
      o.plain_byte   = s[i];
      o.block_last   = (i == 15);
      o.message_last = (i == 15) && msg_end;
      expected_plain.push_back(o);
    end
  endtask

  // transfer on the input side, seen at the rising edge
  logic in_ready_seen;

  // driver: presents queued items, random bursts of idle on the sending side
  int send_gap;
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (!in_valid || in_ready_seen) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (!idle_off && $urandom_range(0, 9) == 0) begin
        send_gap <= $urandom_range(1, 16) - 1;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_data  <= pending_items.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    in_ready_seen <= 1'b0;
    if (!rst && in_valid && in_ready) begin
      in_ready_seen <= 1'b1;
      predict_plaintext(in_data);
    end
  end

  // receiver stall bursts
  int stall_left;
  always @(negedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (!idle_off && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(1, 16) - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // monitor: each output transfer checked against the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_plain.size() == 0) begin
        $error("unexpected output transfer plain_byte=%h", out_data.plain_byte);
        failed = 1'b1;
      end else begin
        want = expected_plain.pop_front();
        if (out_data.plain_byte !== want.plain_byte) begin
          $error("plain_byte exp %h got %h", want.plain_byte, out_data.plain_byte);
          failed = 1'b1;
        end
        if (out_data.block_last !== want.block_last) begin
          $error("block_last exp %b got %b", want.block_last, out_data.block_last);
          failed = 1'b1;
        end
        if (out_data.message_last !== want.message_last) begin
          $error("message_last exp %b got %b", want.message_last, out_data.message_last);
          failed = 1'b1;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic in_item_t key_item(input logic [4:0] slot, input logic [63:0] w);
    in_item_t it;
    it.command = CMD_KEY;
    it.key_slot = slot;
    it.key_word = w;
    it.cipher_byte = 8'($urandom);
    return it;
  endfunction

  function automatic in_item_t data_item(input logic [7:0] b);
    in_item_t it;
    it.command = CMD_DATA;
    it.key_slot = 5'($urandom);
    it.key_word = {$urandom, $urandom};
    it.cipher_byte = b;
    return it;
  endfunction

  // wait until every queued item is sent and every plaintext byte has arrived
  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_plain.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // register write while idle, mirrored in the predictor
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    if (idx == REG_KEY_LEN) mode_reg = val[1:0];
    else if (idx == REG_MSG_BLKS) msg_blocks_reg = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_block_bytes(input int kind);
    for (int i = 0; i < 16; i++)
      pending_items.push_back(data_item(kind == 0 ? 8'h00 : kind == 1 ? 8'hff
                                                   : 8'($urandom)));
  endtask

  initial begin
    int sent_blocks;
    failed = 1'b0; idle_off = 1'b0; cycles = 0;
    in_valid = 1'b0; out_ready = 1'b0; in_data = '0;
    cfg_we = 1'b0; cfg_index = REG_KEY_LEN; cfg_data = '0;
    in_ready_seen = 1'b0;
    for (int i = 0; i < KeySlots; i++) key_table[i] = '0;
    for (int i = 0; i < 16; i++) gather[i] = '0;
    gather_pos = '0; blk_count = '0; mode_reg = MODE_128; msg_blocks_reg = 16'd1;
    rst = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    // directed: fill every slot including extreme words, slots beyond the table ignored
    for (int i = 0; i < KeySlots; i++)
      pending_items.push_back(key_item(5'(i), i == 0 ? 64'h0 : i == 1 ? '1
                                              : {$urandom, $urandom}));
    pending_items.push_back(key_item(5'd31, '1));
    pending_items.push_back(key_item(5'd30, 64'h0));
    push_block_bytes(0);
    drain();
    write_reg(REG_KEY_LEN, 16'd2);
    write_reg(REG_MSG_BLKS, 16'd0);
    push_block_bytes(1);
    drain();
    write_reg(REG_KEY_LEN, 16'd3);
    write_reg(REG_MSG_BLKS, 16'hffff);
    push_block_bytes(2);
    drain();

    // random phases across modes and message lengths
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(REG_KEY_LEN, 16'(ph % 4 == 3 ? 1 : ph));
      write_reg(REG_MSG_BLKS, 16'($urandom_range(1, 3)));
      if (ph == 3) idle_off = 1'b1;
      sent_blocks = 0;
      while (sent_blocks < 1) begin
        // mostly data bytes, some key rewrites mid-block, out-of-range slots included
        if ($urandom_range(0, 15) == 0)
          pending_items.push_back(key_item(5'($urandom_range(0, 31)), {$urandom, $urandom}));
        else
          pending_items.push_back(data_item(8'($urandom)));
        if (pending_items.size() >= 16) begin
          while (pending_items.size() > 0) @(posedge clk);
          sent_blocks++;
        end
      end
      // finish the partial block so no byte is left in the buffer
      while (pending_items.size() > 0 || in_valid) @(posedge clk);
      while (gather_pos != 4'd0) begin
        pending_items.push_back(data_item(8'($urandom)));
        while (pending_items.size() > 0 || in_valid) @(posedge clk);
      end
      drain();
    end

    if (!failed && expected_plain.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
src/aes_dec_pkg.sv
src/aes_dec_round.sv
src/block_cipher_ecb_decrypt_top.sv
tb/tb_block_cipher_ecb_decrypt_top.sv
